// File: rtl/serial_command_frame_decoder_assert.svh
// Assertion macros shared by the frame queue and command stage modules.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SERIAL_COMMAND_FRAME_DECODER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SCFD_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("frame decoder: invariant violated");

// A condition that must hold in the same cycle as its trigger.
`define SCFD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame decoder: implication violated");

// A condition that must hold in the cycle after its trigger.
`define SCFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame decoder: next-cycle check violated");

`endif

// File: rtl/scfd_pkg.sv
// Types and constants of the serial command frame decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package scfd_pkg;

  // Position within a four-byte frame.
  typedef enum logic [1:0] {
    POS_HUNT,
    POS_MODE,
    POS_ANGLE,
    POS_CHECK
  } frame_pos_e;

  // Register value after reset: the default header byte.
  localparam logic [7:0] HEADER_RESET = 8'hAA;

  // Bit positions in the mode byte.
  localparam int unsigned MODE_START_BIT   = 3;
  localparam int unsigned MODE_SCALE_BIT   = 2;
  localparam int unsigned MODE_RUNDIR_BIT  = 1;
  localparam int unsigned MODE_TURNDIR_BIT = 0;

  // Steps are floor(angle * 20 / 9). With 20 * ceil(2^15 / 9) = 72820 and a shift of 15,
  // the excess over the exact quotient stays below 1/9 for every 8-bit angle, so the
  // floor is exact.
  localparam int unsigned STEP_SHIFT = 15;
  localparam logic [16:0] STEP_MUL   = 17'd72820;
  localparam logic [9:0]  STEP_MAX   = 10'd566;

  // A checked frame as it passes from the parser to the command stage.
  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] angle;
  } frame_t;

  // Write side of the frame queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  // Read side of the frame queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } head_t;

  // One stepper command result.
  typedef struct packed {
    logic [7:0] turn_high;
    logic [7:0] turn_low;
    logic [7:0] run_word;
    logic [9:0] step_total;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/scfd_if.sv
// Handshake channels of the serial command frame decoder.
// Self-contained; used by the front, back and top-level modules.
`default_nettype none

// Received serial bytes.
interface scfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Header register writes.
interface scfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_value;
  modport source (output valid, output header_value, input ready);
  modport sink   (input valid, input header_value, output ready);
endinterface

// Stepper command results.
interface scfd_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] turn_high;
  logic [7:0] turn_low;
  logic [7:0] run_word;
  logic [9:0] step_total;
  modport source (output valid, output turn_high, output turn_low, output run_word,
                  output step_total, input ready);
  modport sink   (input valid, input turn_high, input turn_low, input run_word,
                  input step_total, output ready);
endinterface

`default_nettype wire

// File: rtl/serial_command_frame_decoder.sv
// Top level of the serial command frame decoder: parser, frame queue and command stage.
// Depends on scfd_pkg, scfd_if, scfd_front, scfd_queue and scfd_back.
//
//   Channel  Direction  Payload                                   Request
//   rx_i     in         rx_byte[7:0]                              one received byte
//   cfg_i    in         header_value[7:0]                         one header write
//   cmd_o    out        turn_high, turn_low, run_word, step_total one stepper command
//
// One byte is taken every cycle while the frame queue is not full; a good frame's command
// passes through the frame queue and then the output register before it shows.
// rx_i.ready falls only while the frame queue is full; cfg_i.ready is always high.
// Reset puts the parser in hunt, the header register to 0xAA and empties the queue.
// There is no clearing pass: the block takes bytes as soon as reset is released.
`default_nettype none

module serial_command_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  scfd_rx_if.sink     rx_i,
  scfd_cfg_if.sink    cfg_i,
  scfd_cmd_if.source  cmd_o
);
  import scfd_pkg::*;

  push_t push;
  head_t head;
  logic  queue_full;
  logic  pop;

  scfd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .cfg_i  (cfg_i),
    .push_o (push),
    .full_i (queue_full)
  );

  scfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (queue_full)
  );

  scfd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cmd_o  (cmd_o)
  );

endmodule

`default_nettype wire

// File: rtl/scfd_queue.sv
// Short first-in first-out queue of checked frames between parser and command stage.
// Depends on scfd_pkg and the assertion macro header.
`default_nettype none
`include "serial_command_frame_decoder_assert.svh"

module scfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  scfd_pkg::push_t push_i,
  input  wire             pop_i,
  output scfd_pkg::head_t head_o,
  output logic            full_o
);
  import scfd_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t             entry_q [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset: the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.frame;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.frame = entry_q[rd_ptr_q];

  `SCFD_ASSERT_HOLDS(a_count_in_range, count_q <= CNT_W'(DEPTH))
  `SCFD_ASSERT_IMPLIES(a_no_push_when_full, full_o, !push_i.valid)
  `SCFD_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + CNT_W'(1))

endmodule

`default_nettype wire

// File: rtl/scfd_front.sv
// Frame parser: hunts for the header, collects mode and angle, checks the sum byte.
// Depends on scfd_pkg and the channel interfaces in scfd_if.
`default_nettype none

module scfd_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  scfd_rx_if.sink         rx_i,
  scfd_cfg_if.sink        cfg_i,
  output scfd_pkg::push_t push_o,
  input  wire             full_i
);
  import scfd_pkg::*;

  frame_pos_e pos_q, pos_d;
  logic [7:0] header_q;
  logic [7:0] mode_q, mode_d;
  logic [7:0] angle_q, angle_d;
  logic [7:0] sum;
  logic       rx_take;

  // A check byte may push a frame, so bytes wait while the queue is full.
  assign rx_i.ready  = !full_i;
  assign rx_take     = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  // The sum uses the header register as it stands when the check byte arrives.
  assign sum = header_q + mode_q + angle_q;

  // Next frame position.
  always_comb begin
    pos_d = pos_q;
    case (pos_q)
      POS_HUNT: begin
        if (rx_take && (rx_i.rx_byte == header_q)) pos_d = POS_MODE;
      end
      POS_MODE: begin
        if (rx_take) pos_d = POS_ANGLE;
      end
      POS_ANGLE: begin
        if (rx_take) pos_d = POS_CHECK;
      end
      POS_CHECK: begin
        if (rx_take) pos_d = POS_HUNT;
      end
      default: pos_d = POS_HUNT;
    endcase
  end

  // Byte capture and frame push.
  always_comb begin
    mode_d       = mode_q;
    angle_d      = angle_q;
    push_o.valid = 1'b0;
    push_o.frame = '{mode: mode_q, angle: angle_q};
    case (pos_q)
      POS_MODE: begin
        if (rx_take) mode_d = rx_i.rx_byte;
      end
      POS_ANGLE: begin
        if (rx_take) angle_d = rx_i.rx_byte;
      end
      POS_CHECK: begin
        push_o.valid = rx_take && (sum == rx_i.rx_byte);
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_HUNT;
      header_q <= HEADER_RESET;
      mode_q   <= '0;
      angle_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      mode_q  <= mode_d;
      angle_q <= angle_d;
      if (cfg_i.valid && cfg_i.ready) begin
        header_q <= cfg_i.header_value;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/scfd_back.sv
// Command stage: turns a checked frame into stepper command bytes in an output register.
// Depends on scfd_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "serial_command_frame_decoder_assert.svh"

module scfd_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  scfd_pkg::head_t head_i,
  output logic            pop_o,
  scfd_cmd_if.source      cmd_o
);
  import scfd_pkg::*;

  logic        out_valid_q;
  cmd_t        out_q, out_d;
  logic [24:0] product;
  logic [9:0]  steps;
  logic [7:0]  mode;

  // Take the queue head whenever the output register is free or being emptied.
  assign pop_o = head_i.valid && (!out_valid_q || cmd_o.ready);

  // Step count by multiplication with a scaled reciprocal of 9.
  assign mode    = head_i.frame.mode;
  assign product = 25'(head_i.frame.angle) * 25'(STEP_MUL);
  assign steps   = product[STEP_SHIFT +: 10];

  // Command bytes from the mode flags and the step count.
  always_comb begin
    out_d.turn_high  = {mode[MODE_START_BIT], mode[MODE_TURNDIR_BIT], 4'b0000, steps[9:8]};
    out_d.turn_low   = steps[7:0];
    out_d.run_word   = {1'b0, mode[MODE_START_BIT], mode[MODE_SCALE_BIT], 4'b0000,
                        mode[MODE_RUNDIR_BIT]};
    out_d.step_total = steps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign cmd_o.valid      = out_valid_q;
  assign cmd_o.turn_high  = out_q.turn_high;
  assign cmd_o.turn_low   = out_q.turn_low;
  assign cmd_o.run_word   = out_q.run_word;
  assign cmd_o.step_total = out_q.step_total;

  `SCFD_ASSERT_IMPLIES(a_steps_in_range, out_valid_q, out_q.step_total <= STEP_MAX)
  `SCFD_ASSERT_IMPLIES(a_turn_matches_steps, out_valid_q,
                       (out_q.turn_high[1:0] == out_q.step_total[9:8]) &&
                       (out_q.turn_low == out_q.step_total[7:0]))
  `SCFD_ASSERT_NEXT(a_pop_fills_output, pop_o, out_valid_q)

endmodule

`default_nettype wire

// File: bench/serial_command_frame_decoder_tb.sv
// Self-checking bench for serial_command_frame_decoder: byte, header and command channels.
// Depends on scfd_pkg and the channel interfaces in scfd_if; drives and checks the top level.
`default_nettype none

module serial_command_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scfd_pkg::*;

  // Steps per degree as a fraction: floor(angle * 20 / 9).
  localparam int unsigned STEP_NUMER  = 20;
  localparam int unsigned STEP_DENOM  = 9;
  // Cycles with no accepted request before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles left for the pipeline to settle before a header write or the end.
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scfd_rx_if  rx_if ();
  scfd_cfg_if cfg_if ();
  scfd_cmd_if cmd_if ();

  serial_command_frame_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .cmd_o  (cmd_if)
  );

  always #6 clk_i = ~clk_i;

  // Bench copy of the parser state and the header register.
  frame_pos_e  parse_pos;
  logic [7:0]  header_now;
  logic [7:0]  mode_seen;
  logic [7:0]  angle_seen;

  logic [7:0]  rx_pending_q[$];
  cmd_t        cmd_expected_q[$];

  int unsigned rx_gap, rx_calm, cmd_stall, cmd_calm;
  int unsigned bytes_taken, cmds_checked, frames_queued, headers_written;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Length of an idle stretch: mostly none, some short, a few long, with calm runs.
  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Advance the frame parser by one byte; a good check byte yields one command.
  function automatic void decode_byte(input logic [7:0] rx);
    logic [7:0]  sum;
    logic [9:0]  steps;
    int unsigned angle_wide;
    cmd_t        cmd;
    case (parse_pos)
      POS_HUNT: begin
        if (rx == header_now) parse_pos = POS_MODE;
      end
      POS_MODE: begin
        mode_seen = rx;
        parse_pos = POS_ANGLE;
      end
      POS_ANGLE: begin
        angle_seen = rx;
        parse_pos = POS_CHECK;
      end
      default: begin
        parse_pos = POS_HUNT;
        sum = header_now + mode_seen + angle_seen;
        if (sum == rx) begin
          angle_wide = angle_seen;
          steps = 10'((angle_wide * STEP_NUMER) / STEP_DENOM);
          cmd.turn_high  = {mode_seen[MODE_START_BIT], mode_seen[MODE_TURNDIR_BIT], 4'b0000,
                            steps[9:8]};
          cmd.turn_low   = steps[7:0];
          cmd.run_word   = {1'b0, mode_seen[MODE_START_BIT], mode_seen[MODE_SCALE_BIT], 4'b0000,
                            mode_seen[MODE_RUNDIR_BIT]};
          cmd.step_total = steps;
          cmd_expected_q.push_back(cmd);
        end
      end
    endcase
  endfunction

  // Byte driver: offers the next pending byte and predicts each accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.rx_byte);
        bytes_taken++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_if.valid <= 1'b0;
        end else if (rx_pending_q.size() > 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_pending_q.pop_front();
          rx_gap = idle_len(rx_calm);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor: checks each accepted command and stalls ready at random.
  always @(posedge clk_i) begin
    cmd_t want;
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
      cmd_stall = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        if (cmd_expected_q.size() == 0) begin
          note_mismatch($sformatf("command th=%h tl=%h rw=%h st=%0d with none expected",
                        cmd_if.turn_high, cmd_if.turn_low, cmd_if.run_word,
                        cmd_if.step_total));
        end else begin
          want = cmd_expected_q.pop_front();
          if (cmd_if.turn_high !== want.turn_high || cmd_if.turn_low !== want.turn_low ||
              cmd_if.run_word !== want.run_word || cmd_if.step_total !== want.step_total) begin
            note_mismatch($sformatf(
              "command %0d: expected th=%h tl=%h rw=%h st=%0d, got th=%h tl=%h rw=%h st=%0d",
              cmds_checked, want.turn_high, want.turn_low, want.run_word, want.step_total,
              cmd_if.turn_high, cmd_if.turn_low, cmd_if.run_word, cmd_if.step_total));
          end
        end
        cmds_checked++;
      end
      if (cmd_stall > 0) begin
        cmd_stall--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) cmd_stall = idle_len(cmd_calm);
      end
    end
  end

  // Watchdog: counts cycles in which no request is accepted on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (cmd_if.valid && cmd_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Queue one four-byte frame under the current header; a broken one has a bad check.
  task automatic queue_frame(input logic [7:0] mode, input logic [7:0] angle,
                             input bit intact);
    logic [7:0] check;
    check = header_now + mode + angle;
    if (!intact) check = check ^ 8'($urandom_range(1, 255));
    rx_pending_q.push_back(header_now);
    rx_pending_q.push_back(mode);
    rx_pending_q.push_back(angle);
    rx_pending_q.push_back(check);
    if (intact) frames_queued++;
  endtask

  // Hold off until every byte is taken and every command has come, then let it settle.
  task automatic wait_drained();
    while (rx_pending_q.size() > 0 || rx_if.valid) @(posedge clk_i);
    while (cmd_expected_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] value);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.header_value <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    header_now = value;
    headers_written++;
  endtask

  // Mostly well-formed frames with random content, some broken ones and some line noise.
  task automatic random_phase(input int unsigned n_bytes);
    int unsigned r, k;
    logic [7:0]  angle;
    while (rx_pending_q.size() < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 75 || r >= 87) begin
        angle = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) angle = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        queue_frame(8'($urandom_range(0, 255)), angle, r < 75);
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          if ($urandom_range(0, 4) == 0) rx_pending_q.push_back(header_now);
          else rx_pending_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    rx_if.valid         = 1'b0;
    rx_if.rx_byte       = 8'h00;
    cfg_if.valid        = 1'b0;
    cfg_if.header_value = 8'h00;
    cmd_if.ready        = 1'b0;
    parse_pos  = POS_HUNT;
    header_now = HEADER_RESET;
    mode_seen  = 8'h00;
    angle_seen = 8'h00;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored bytes while hunting, extreme angles and modes, header value as
    // data, ignored mode bits and a frame with a bad check.
    rx_pending_q.push_back(8'h00);
    rx_pending_q.push_back(8'hFF);
    queue_frame(8'h0F, 8'hFF, 1'b1);
    queue_frame(8'hF0, 8'h00, 1'b1);
    queue_frame(8'h05, HEADER_RESET, 1'b1);
    queue_frame(HEADER_RESET, 8'd9, 1'b1);
    queue_frame(8'h0A, 8'd100, 1'b0);
    wait_drained();

    // Header changed between the mode and angle bytes: the check uses the new value.
    rx_pending_q.push_back(header_now);
    rx_pending_q.push_back(8'h03);
    wait_drained();
    write_header(8'h00);
    rx_pending_q.push_back(8'd200);
    rx_pending_q.push_back(8'h00 + 8'h03 + 8'd200);
    frames_queued++;
    wait_drained();

    // Random phases under several header settings, the extremes among them.
    write_header(8'hFF);
    random_phase(115);
    wait_drained();
    write_header(8'h00);
    random_phase(115);
    wait_drained();
    write_header(8'($urandom_range(1, 254)));
    random_phase(115);
    wait_drained();
    write_header(8'($urandom_range(1, 254)));
    random_phase(115);
    wait_drained();
    write_header(HEADER_RESET);
    random_phase(115);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    mismatches += cmd_expected_q.size();
    $display("Run covered %0d bytes with %0d good frames queued and %0d header writes.",
             bytes_taken, frames_queued, headers_written);
    $display("%0d stepper commands checked, %0d mismatches.", cmds_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
